/* src/wsp_pkg.sv */
package wsp_pkg;

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_FORMAT = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	localparam logic [1:0] ERR_HEADER    = 2'd0;
	localparam logic [1:0] ERR_FMT_SHORT = 2'd1;
	localparam logic [1:0] ERR_NO_DATA   = 2'd2;

	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] sample;
		logic [31:0] rate_hz;
		logic        stereo;
		logic        wide;
		logic [1:0]  error_code;
		logic        last;
	} wsp_res_t;

	function automatic logic [7:0] riff_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = 8'h52;
			2'd1:    b = 8'h49;
			2'd2:    b = 8'h46;
			default: b = 8'h46;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] wavefmt_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0:    b = 8'h57;
			3'd1:    b = 8'h41;
			3'd2:    b = 8'h56;
			3'd3:    b = 8'h45;
			3'd4:    b = 8'h66;
			3'd5:    b = 8'h6D;
			3'd6:    b = 8'h74;
			default: b = 8'h20;
		endcase
		return b;
	endfunction

	function automatic wsp_res_t mk_res(input logic [1:0] kind, input logic [15:0] smp,
			input logic [31:0] rate, input logic st, input logic wd, input logic [1:0] err);
		wsp_res_t r;
		r.kind        = kind;
		r.sample      = smp;
		r.rate_hz     = rate;
		r.stereo      = st;
		r.wide        = wd;
		r.error_code  = err;
		r.last        = 1'b0;
		return r;
	endfunction

endpackage

/* src/wav_stream_parser.sv */
// Byte-serial WAV parser: takes one file byte per word on the input channel, checks the
// 36-byte RIFF/PCM header, skips the rest of the fmt chunk and any other chunks, then
// emits a format word followed by samples (bytes, or little-endian pairs for 16-bit
// files) and a done word, or a single error word. A byte is taken every cycle while the
// output side keeps up; a byte that yields two words (format with an empty data chunk,
// or the final sample with done) holds the input until the first of the two has left,
// since the two-slot result buffer delivers one word per cycle. start_req on a word
// restarts parsing with that word's byte as header byte 0.
module wav_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        start_req,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] sample,
	output logic [31:0] rate_hz,
	output logic        stereo,
	output logic        wide,
	output logic [1:0]  error_code,
	output logic        last
);
	import wsp_pkg::*;

	wsp_res_t   res0;
	wsp_res_t   res1;
	wsp_res_t   head;
	logic [1:0] nres;
	logic       fire;

	assign fire = in_valid && in_ready;

	wsp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.data_byte   (data_byte),
		.start_req   (start_req),
		.end_of_file (end_of_file),
		.res0        (res0),
		.res1        (res1),
		.nres        (nres)
	);

	wsp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.res0      (res0),
		.res1      (res1),
		.nres      (nres),
		.take_ok   (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign kind        = head.kind;
	assign sample      = head.sample;
	assign rate_hz     = head.rate_hz;
	assign stereo      = head.stereo;
	assign wide        = head.wide;
	assign error_code  = head.error_code;
	assign last        = head.last;

endmodule

/* src/wsp_core.sv */
module wsp_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [7:0]       data_byte,
	input  logic             start_req,
	input  logic             end_of_file,
	output wsp_pkg::wsp_res_t res0,
	output wsp_pkg::wsp_res_t res1,
	output logic [1:0]       nres
);
	import wsp_pkg::*;

	localparam logic [2:0] PH_IDLE       = 3'd0;
	localparam logic [2:0] PH_HEADER     = 3'd1;
	localparam logic [2:0] PH_FMT_SKIP   = 3'd2;
	localparam logic [2:0] PH_CHUNK_HDR  = 3'd3;
	localparam logic [2:0] PH_CHUNK_SKIP = 3'd4;
	localparam logic [2:0] PH_DATA       = 3'd5;
	localparam logic [2:0] PH_FINISHED   = 3'd6;

	logic [2:0]  phase_q, phase_d;
	logic [5:0]  pos_q, pos_d;
	logic [31:0] fa_q, fa_d;
	logic        hbad_q, hbad_d;
	logic [31:0] fmt_q, fmt_d;
	logic [31:0] rate_q, rate_d;
	logic        stereo_q, stereo_d;
	logic        wide_q, wide_d;
	logic [31:0] rem_q, rem_d;
	logic [31:0] tag_q, tag_d;
	logic [7:0]  low_q, low_d;
	logic        held_q, held_d;

	always_comb begin
		logic [15:0] half;
		wsp_res_t    r;
		phase_d  = phase_q;
		pos_d    = pos_q;
		fa_d     = fa_q;
		hbad_d   = hbad_q;
		fmt_d    = fmt_q;
		rate_d   = rate_q;
		stereo_d = stereo_q;
		wide_d   = wide_q;
		rem_d    = rem_q;
		tag_d    = tag_q;
		low_d    = low_q;
		held_d   = held_q;
		res0     = '0;
		res1     = '0;
		nres     = 2'd0;
		half     = '0;
		r        = '0;

		if (start_req) begin
			pos_d    = '0;
			fa_d     = '0;
			hbad_d   = 1'b0;
			fmt_d    = '0;
			rate_d   = '0;
			stereo_d = 1'b0;
			wide_d   = 1'b0;
			rem_d    = '0;
			tag_d    = '0;
			low_d    = '0;
			held_d   = 1'b0;
			phase_d  = PH_HEADER;
		end

		if (end_of_file) begin
			case (phase_d)
				PH_HEADER: begin
					phase_d = PH_FINISHED;
					res0 = mk_res(KIND_ERROR, '0, '0, 1'b0, 1'b0, ERR_HEADER);
					nres = 2'd1;
				end
				PH_FMT_SKIP, PH_CHUNK_HDR, PH_CHUNK_SKIP: begin
					phase_d = PH_FINISHED;
					res0 = mk_res(KIND_ERROR, '0, '0, 1'b0, 1'b0, ERR_NO_DATA);
					nres = 2'd1;
				end
				PH_DATA: begin
					held_d  = 1'b0;
					phase_d = PH_FINISHED;
					res0 = mk_res(KIND_DONE, '0, '0, 1'b0, 1'b0, ERR_HEADER);
					nres = 2'd1;
				end
				default: ;
			endcase
		end else begin
			case (phase_d)
				PH_HEADER: begin
					fa_d = {data_byte, fa_d[31:8]};
					half = fa_d[31:16];
					if (pos_d == 6'd35) begin
						if (half < 16'd8 || half > 16'd16)
							hbad_d = 1'b1;
						wide_d = half[4];
						if (hbad_d) begin
							phase_d = PH_FINISHED;
							res0 = mk_res(KIND_ERROR, '0, '0, 1'b0, 1'b0, ERR_HEADER);
							nres = 2'd1;
						end else if (fmt_d < 32'd16) begin
							// a short fmt chunk would need a backward seek
							phase_d = PH_FINISHED;
							res0 = mk_res(KIND_ERROR, '0, '0, 1'b0, 1'b0, ERR_FMT_SHORT);
							nres = 2'd1;
						end else begin
							pos_d = '0;
							fa_d  = '0;
							if (fmt_d == 32'd16) begin
								phase_d = PH_CHUNK_HDR;
							end else begin
								rem_d   = fmt_d - 32'd16;
								phase_d = PH_FMT_SKIP;
							end
						end
					end else begin
						if (pos_d < 6'd4) begin
							if (data_byte != riff_byte(pos_d[1:0]))
								hbad_d = 1'b1;
						end else if (pos_d >= 6'd8 && pos_d < 6'd16) begin
							if (data_byte != wavefmt_byte(pos_d[2:0]))
								hbad_d = 1'b1;
						end else if (pos_d == 6'd19) begin
							fmt_d = fa_d;
						end else if (pos_d == 6'd21) begin
							if (half != 16'd1)
								hbad_d = 1'b1;
						end else if (pos_d == 6'd23) begin
							if (half == 16'd0 || half > 16'd2)
								hbad_d = 1'b1;
							stereo_d = (half == 16'd2);
						end else if (pos_d == 6'd27) begin
							rate_d = fa_d;
						end
						pos_d = pos_d + 6'd1;
					end
				end
				PH_FMT_SKIP, PH_CHUNK_SKIP: begin
					rem_d = rem_d - 32'd1;
					if (rem_d == 32'd0) begin
						phase_d = PH_CHUNK_HDR;
						pos_d   = '0;
						fa_d    = '0;
					end
				end
				PH_CHUNK_HDR: begin
					fa_d = {data_byte, fa_d[31:8]};
					if (pos_d == 6'd3)
						tag_d = fa_d;
					if (pos_d < 6'd7) begin
						pos_d = pos_d + 6'd1;
					end else begin
						pos_d = '0;
						rem_d = fa_d;
						fa_d  = '0;
						if (tag_d == TAG_DATA) begin
							phase_d = PH_DATA;
							held_d  = 1'b0;
							res0 = mk_res(KIND_FORMAT, '0, rate_d, stereo_d, wide_d, ERR_HEADER);
							nres = 2'd1;
							if (rem_d == 32'd0) begin
								phase_d = PH_FINISHED;
								res1 = mk_res(KIND_DONE, '0, '0, 1'b0, 1'b0, ERR_HEADER);
								nres = 2'd2;
							end
						end else if (rem_d != 32'd0) begin
							phase_d = PH_CHUNK_SKIP;
						end
					end
				end
				PH_DATA: begin
					rem_d = rem_d - 32'd1;
					if (wide_d) begin
						if (!held_d) begin
							low_d  = data_byte;
							held_d = 1'b1;
						end else begin
							held_d = 1'b0;
							res0 = mk_res(KIND_SAMPLE, {data_byte, low_d}, '0, 1'b0, 1'b0,
								ERR_HEADER);
							nres = 2'd1;
						end
					end else begin
						res0 = mk_res(KIND_SAMPLE, {8'd0, data_byte}, '0, 1'b0, 1'b0, ERR_HEADER);
						nres = 2'd1;
					end
					if (rem_d == 32'd0) begin
						held_d  = 1'b0;
						phase_d = PH_FINISHED;
						r = mk_res(KIND_DONE, '0, '0, 1'b0, 1'b0, ERR_HEADER);
						if (nres == 2'd0)
							res0 = r;
						else
							res1 = r;
						nres = nres + 2'd1;
					end
				end
				default: ;
			endcase
		end

		if (nres == 2'd1)
			res0.last = 1'b1;
		if (nres == 2'd2)
			res1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pos_q    <= '0;
			fa_q     <= '0;
			hbad_q   <= 1'b0;
			fmt_q    <= '0;
			rate_q   <= '0;
			stereo_q <= 1'b0;
			wide_q   <= 1'b0;
			rem_q    <= '0;
			tag_q    <= '0;
			low_q    <= '0;
			held_q   <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			fa_q     <= fa_d;
			hbad_q   <= hbad_d;
			fmt_q    <= fmt_d;
			rate_q   <= rate_d;
			stereo_q <= stereo_d;
			wide_q   <= wide_d;
			rem_q    <= rem_d;
			tag_q    <= tag_d;
			low_q    <= low_d;
			held_q   <= held_d;
		end
	end

endmodule

/* src/wsp_outbuf.sv */
module wsp_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  wsp_pkg::wsp_res_t res0,
	input  wsp_pkg::wsp_res_t res1,
	input  logic [1:0]        nres,
	output logic              take_ok,
	output logic              out_valid,
	input  logic              out_ready,
	output wsp_pkg::wsp_res_t head
);
	import wsp_pkg::*;

	logic [1:0] cnt_q;
	wsp_res_t   slot0_q;
	wsp_res_t   slot1_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	// room for a full pair of results once the head word leaves
	assign take_ok   = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);
	assign head      = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= nres;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= res0;
			slot1_q <= res1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule
